### src/oale_pkg.sv
// Shared codes and controller/datapath interface types for the ordered list engine.
package oale_pkg;

  localparam logic [2:0] REQ_GET    = 3'd0;
  localparam logic [2:0] REQ_SET    = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_SEARCH = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    PTR_POS,
    PTR_POS_INC,
    PTR_LAST,
    PTR_ZERO
  } ptr_sel_e;

  typedef struct packed {
    logic     latch;
    logic     ptr_load;
    ptr_sel_e ptr_sel;
    logic     ptr_step;
    logic     rd_en;
    logic     commit;
    logic     wr_val;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cap_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       pos_lt_n;
    logic       pos_eq_n;
    logic       pos_last;
    logic       full;
    logic       empty;
    logic       at_end;
    logic       rvalid;
  } dp_stat_t;

endpackage

### src/oale_dpath.sv
// Datapath: request registers, element store, walk pointer, length counter and result registers.
module oale_dpath import oale_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dp_cmd_t                              cmd_i,
  output dp_stat_t                             stat_o,
  input  logic [2:0]                           req_type_i,
  input  logic [$clog2(CAPACITY+1)-1:0]        position_i,
  input  logic signed [DataW-1:0]              item_value_i,
  output logic signed [DataW-1:0]              read_value_o,
  output logic                                 found_o,
  output logic [$clog2(CAPACITY+1)-1:0]        list_length_o
);

  localparam int unsigned IdxW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);

  logic [DataW-1:0] mem_q [CAPACITY];

  logic [2:0]              req_type_q;
  logic [IdxW-1:0]         pos_q;
  logic [DataW-1:0]        val_q;
  logic [IdxW-1:0]         count_q, count_d;
  logic [AddrW-1:0]        ptr_q, ptr_d;
  logic [AddrW-1:0]        raddr_q;
  logic                    rvalid_q;
  logic [DataW-1:0]        rdata_q;
  logic [DataW-1:0]        rd_val_q;
  logic                    found_q;

  logic                    is_insert;
  logic [IdxW-1:0]         end_idx;
  logic [AddrW-1:0]        waddr;

  assign is_insert = (req_type_q == REQ_INSERT);
  // insert walks down to the insert point, delete and search walk up to the last entry
  assign end_idx   = is_insert ? pos_q : (count_q - IdxW'(1));
  assign waddr     = is_insert ? (raddr_q + AddrW'(1)) : (raddr_q - AddrW'(1));

  always_comb begin
    stat_o.req_type = req_type_q;
    stat_o.pos_lt_n = (pos_q < count_q);
    stat_o.pos_eq_n = (pos_q == count_q);
    stat_o.pos_last = ((pos_q + IdxW'(1)) == count_q);
    stat_o.full     = (count_q == IdxW'(CAPACITY));
    stat_o.empty    = (count_q == '0);
    stat_o.at_end   = (IdxW'(ptr_q) == end_idx);
    stat_o.rvalid   = rvalid_q;
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_load) begin
      unique case (cmd_i.ptr_sel)
        PTR_POS:     ptr_d = AddrW'(pos_q);
        PTR_POS_INC: ptr_d = AddrW'(pos_q) + AddrW'(1);
        PTR_LAST:    ptr_d = AddrW'(count_q - IdxW'(1));
        PTR_ZERO:    ptr_d = '0;
        default:     ptr_d = '0;
      endcase
    end else if (cmd_i.ptr_step) begin
      ptr_d = is_insert ? (ptr_q - AddrW'(1)) : (ptr_q + AddrW'(1));
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + IdxW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rvalid_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.latch) begin
      req_type_q <= req_type_i;
      pos_q      <= position_i;
      val_q      <= item_value_i;
      rd_val_q   <= '0;
      found_q    <= 1'b0;
    end else begin
      if (cmd_i.cap_rd) begin
        rd_val_q <= rdata_q;
      end
      if (cmd_i.commit && (req_type_q == REQ_SEARCH) && (rdata_q == val_q)) begin
        found_q <= 1'b1;
      end
    end
    if (cmd_i.rd_en) begin
      raddr_q <= ptr_q;
    end
  end

  // element store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[ptr_q];
    end
    if (cmd_i.wr_val) begin
      mem_q[AddrW'(pos_q)] <= val_q;
    end else if (cmd_i.commit && (req_type_q != REQ_SEARCH)) begin
      mem_q[waddr] <= rdata_q;
    end
  end

  assign read_value_o  = rd_val_q;
  assign found_o       = found_q;
  assign list_length_o = count_q;

`ifndef SYNTH
  a_commit_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> rvalid_q)
    else $error("shift or compare without read data");
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= IdxW'(CAPACITY))
    else $error("length beyond capacity");
  a_no_grow_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (count_q != IdxW'(CAPACITY)))
    else $error("grow on full list");
`endif

endmodule

### src/oale_ctrl.sv
// Controller: sequences each request over the datapath and produces status and the result strobe.
module oale_ctrl import oale_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output logic       done_o,
  output logic [1:0] status_o,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_RDW    = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_FINW   = 3'd6;
  localparam logic [2:0] S_REPLY  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] st_q, st_d;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        st_d    = ST_OK;
        state_d = S_REPLY;
        unique case (stat_i.req_type)
          REQ_GET: begin
            if (stat_i.pos_lt_n) begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = PTR_POS;
              state_d        = S_RD;
            end else begin
              st_d = ST_BAD_INDEX;
            end
          end
          REQ_SET: begin
            if (stat_i.pos_lt_n) begin
              cmd_o.wr_val = 1'b1;
            end else if (stat_i.pos_eq_n && !stat_i.full) begin
              cmd_o.wr_val  = 1'b1;
              cmd_o.cnt_inc = 1'b1;
            end else if (stat_i.pos_eq_n) begin
              st_d = ST_FULL;
            end else begin
              st_d = ST_BAD_INDEX;
            end
          end
          REQ_INSERT: begin
            if (!stat_i.pos_lt_n && !stat_i.pos_eq_n) begin
              st_d = ST_BAD_INDEX;
            end else if (stat_i.full) begin
              st_d = ST_FULL;
            end else if (stat_i.pos_eq_n) begin
              cmd_o.wr_val  = 1'b1;
              cmd_o.cnt_inc = 1'b1;
            end else begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = PTR_LAST;
              state_d        = S_SHIFT;
            end
          end
          REQ_DELETE: begin
            if (stat_i.empty) begin
              st_d = ST_EMPTY;
            end else if (!stat_i.pos_lt_n) begin
              st_d = ST_BAD_INDEX;
            end else if (stat_i.pos_last) begin
              // delete of the last entry: nothing to move
              state_d = S_DRAIN;
            end else begin
              // pointer starts one above the hole
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = PTR_POS_INC;
              state_d        = S_SHIFT;
            end
          end
          REQ_SEARCH: begin
            if (!stat_i.empty) begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = PTR_ZERO;
              state_d        = S_SHIFT;
            end
          end
          default: begin
            st_d = ST_OK;
          end
        endcase
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RDW;
      end
      S_RDW: begin
        cmd_o.cap_rd = 1'b1;
        state_d      = S_REPLY;
      end
      S_SHIFT: begin
        cmd_o.commit = stat_i.rvalid;
        cmd_o.rd_en  = 1'b1;
        if (stat_i.at_end) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.ptr_step = 1'b1;
        end
      end
      S_DRAIN: begin
        cmd_o.commit = stat_i.rvalid;
        if (stat_i.req_type == REQ_INSERT) begin
          state_d = S_FINW;
        end else begin
          cmd_o.cnt_dec = (stat_i.req_type == REQ_DELETE);
          state_d       = S_REPLY;
        end
      end
      S_FINW: begin
        cmd_o.wr_val  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_REPLY;
      end
      S_REPLY: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = (state_q == S_REPLY);
  assign status_o = st_q;

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");
  a_idle_after_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("controller not idle after result");
`endif

endmodule

### src/ordered_array_list_engine_unit.sv
// Top level of the ordered list engine: controller plus datapath with the element store.
//
// Usage: drive req_type_i, position_i and item_value_i and raise start while busy is low;
// the item is taken at that clock edge. busy stays high until the result has been shown.
// The result appears on read_value_o, found_o, status_o and list_length_o for exactly one
// cycle, marked by done_o; the receiver cannot hold it off, so it must capture it then.
// A search walks the whole list, with no early exit on a hit. Busy drops in the cycle
// after done_o, and only then is a new item taken; insert, delete and search move or
// compare entries one per cycle through the store, which has one read and one write port.
// Reset (rst_ni low, asynchronous) empties the list and returns the controller to idle;
// store contents are not cleared, only positions below the length are ever read.
module ordered_array_list_engine_unit import oale_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           req_type_i,
  input  logic [$clog2(CAPACITY+1)-1:0]        position_i,
  input  logic signed [DataW-1:0]              item_value_i,
  output logic                                 done_o,
  output logic signed [DataW-1:0]              read_value_o,
  output logic                                 found_o,
  output logic [1:0]                           status_o,
  output logic [$clog2(CAPACITY+1)-1:0]        list_length_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  oale_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_o (status_o),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  oale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .read_value_o  (read_value_o),
    .found_o       (found_o),
    .list_length_o (list_length_o)
  );

endmodule

### verif/tb.sv
// Self-checking testbench for the ordered list engine: directed, full-list and random requests.
module tb;
  import oale_pkg::*;

  localparam int CAPACITY = 64;
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int POS_MAX  = (1 << POS_W) - 1;
  localparam logic signed [DataW-1:0] WORD_MIN = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] WORD_MAX = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [2:0] REQ_LAST_CODE = 3'd7;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    hit;
    logic [1:0]              code;
    pos_t                    length;
  } list_reply_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [2:0]              req_type_i;
  pos_t                    position_i;
  logic signed [DataW-1:0] item_value_i;
  logic                    done_o;
  logic signed [DataW-1:0] read_value_o;
  logic                    found_o;
  logic [1:0]              status_o;
  pos_t                    list_length_o;

  // shadow copy of the list
  logic signed [DataW-1:0] shadow_words [CAPACITY];
  int                      shadow_len;

  list_reply_t pending_replies[$];
  int          fail_count;
  int          burst_left;
  int          op_tally [8];
  int          status_tally [4];
  int          search_hits;
  int          longest_list;
  int          replies_seen;

  ordered_array_list_engine_unit #(.CAPACITY(CAPACITY)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .done_o        (done_o),
    .read_value_o  (read_value_o),
    .found_o       (found_o),
    .status_o      (status_o),
    .list_length_o (list_length_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic list_reply_t apply_list_request(input logic [2:0] kind, input pos_t pos,
                                                     input logic signed [DataW-1:0] val);
    list_reply_t r;
    int          n;
    r = '0;
    n = shadow_len;
    case (kind)
      REQ_GET: begin
        if (pos < n) r.value = shadow_words[pos];
        else r.code = ST_BAD_INDEX;
      end
      REQ_SET: begin
        if (pos < n) begin
          shadow_words[pos] = val;
        end else if (pos == n) begin
          if (n >= CAPACITY) begin
            r.code = ST_FULL;
          end else begin
            shadow_words[n] = val;
            shadow_len = n + 1;
          end
        end else begin
          r.code = ST_BAD_INDEX;
        end
      end
      REQ_INSERT: begin
        // index is checked before capacity
        if (pos > n) begin
          r.code = ST_BAD_INDEX;
        end else if (n >= CAPACITY) begin
          r.code = ST_FULL;
        end else begin
          for (int j = n; j > pos; j--) shadow_words[j] = shadow_words[j-1];
          shadow_words[pos] = val;
          shadow_len = n + 1;
        end
      end
      REQ_DELETE: begin
        // empty is checked before index
        if (n == 0) begin
          r.code = ST_EMPTY;
        end else if (pos >= n) begin
          r.code = ST_BAD_INDEX;
        end else begin
          for (int j = pos; j < n - 1; j++) shadow_words[j] = shadow_words[j+1];
          shadow_len = n - 1;
        end
      end
      REQ_SEARCH: begin
        for (int j = 0; j < n; j++) if (shadow_words[j] == val) r.hit = 1'b1;
      end
      default: ;
    endcase
    r.length = pos_t'(shadow_len);
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2, 3, 4: return $urandom_range(0, 16) - 8;
      default: return $urandom();
    endcase
  endfunction

  // mostly values already held, so that searches hit
  function automatic logic signed [DataW-1:0] search_word();
    if (shadow_len > 0 && $urandom_range(0, 9) < 6)
      return shadow_words[$urandom_range(0, shadow_len - 1)];
    return random_word();
  endfunction

  // mostly within 0..limit, otherwise past it; any position if limit is out of range
  function automatic pos_t pick_position(input int limit);
    if (limit < 0 || limit >= POS_MAX) return pos_t'($urandom_range(0, POS_MAX));
    if ($urandom_range(0, 99) < 85) return pos_t'($urandom_range(0, limit));
    return pos_t'($urandom_range(limit + 1, POS_MAX));
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i) start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic send_request(input logic [2:0] kind, input pos_t pos,
                              input logic signed [DataW-1:0] val);
    list_reply_t want;
    @(negedge clk_i);
    req_type_i   <= kind;
    position_i   <= pos;
    item_value_i <= val;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy);
    want = apply_list_request(kind, pos, val);
    pending_replies.push_back(want);
    op_tally[kind]++;
    status_tally[want.code]++;
    if (want.hit) search_hits++;
    if (shadow_len > longest_list) longest_list = shadow_len;
    pace_sender();
  endtask

  always @(posedge clk_i) begin
    list_reply_t want;
    list_reply_t got;
    if (rst_ni && done_o) begin
      got = '{read_value_o, found_o, status_o, list_length_o};
      replies_seen++;
      if (pending_replies.size() == 0) begin
        note_failure("result with no item outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (got !== want)
          note_failure($sformatf(
            "mismatch: value %0d/%0d found %0b/%0b status %0d/%0d length %0d/%0d (exp/got)",
            $signed(want.value), $signed(got.value), want.hit, got.hit,
            want.code, got.code, want.length, got.length));
      end
    end
  end

  task automatic test_edge_requests();
    // empty list
    send_request(REQ_GET, 0, 0);
    send_request(REQ_SET, 1, 5);
    send_request(REQ_INSERT, 1, 5);
    send_request(REQ_DELETE, 0, 0);
    send_request(REQ_DELETE, pos_t'(POS_MAX), 0);
    send_request(REQ_SEARCH, 0, 0);
    for (int k = REQ_SEARCH + 1; k <= REQ_LAST_CODE; k++)
      send_request(3'(k), pos_t'($urandom_range(0, POS_MAX)), $urandom());
    // small list built from extremes
    send_request(REQ_SET, 0, WORD_MIN);
    send_request(REQ_INSERT, 0, WORD_MAX);
    send_request(REQ_INSERT, 2, -1);
    send_request(REQ_INSERT, 1, 0);
    send_request(REQ_GET, 0, 0);
    send_request(REQ_GET, 3, 0);
    send_request(REQ_GET, 4, 0);
    send_request(REQ_GET, pos_t'(POS_MAX), 0);
    send_request(REQ_SET, 1, 32'sh5555_5555);
    send_request(REQ_SET, 5, 7);
    send_request(REQ_SEARCH, 0, WORD_MIN);
    send_request(REQ_SEARCH, 0, 1);
    send_request(REQ_DELETE, 4, 0);
    send_request(REQ_DELETE, 0, 0);
    send_request(REQ_DELETE, 2, 0);
    send_request(REQ_SEARCH, 0, WORD_MAX);
  endtask

  task automatic test_full_list();
    while (shadow_len < CAPACITY) begin
      if ($urandom_range(0, 3) == 0)
        send_request(REQ_SET, pos_t'(shadow_len), random_word());
      else
        send_request(REQ_INSERT, pos_t'($urandom_range(0, shadow_len)), random_word());
    end
    send_request(REQ_SET, pos_t'(CAPACITY), random_word());
    send_request(REQ_INSERT, pos_t'(CAPACITY), random_word());
    send_request(REQ_INSERT, 0, random_word());
    send_request(REQ_INSERT, pos_t'(CAPACITY + 1), random_word());
    send_request(REQ_SET, pos_t'(POS_MAX), random_word());
    send_request(REQ_GET, pos_t'(CAPACITY - 1), 0);
    send_request(REQ_GET, pos_t'(CAPACITY), 0);
    send_request(REQ_SEARCH, 0, shadow_words[CAPACITY-1]);
    send_request(REQ_SEARCH, 0, random_word());
    send_request(REQ_DELETE, pos_t'(CAPACITY - 1), 0);
    send_request(REQ_SET, pos_t'(CAPACITY - 1), random_word());
    while (shadow_len > 0) begin
      if ($urandom_range(0, 4) == 0) send_request(REQ_SEARCH, 0, search_word());
      send_request(REQ_DELETE, pos_t'($urandom_range(0, shadow_len - 1)), 0);
    end
    send_request(REQ_DELETE, 0, 0);
  endtask

  task automatic test_random_traffic(input int count);
    bit   growing;
    int   pick;
    pos_t pos;
    growing = 1'b1;
    repeat (count) begin
      if (shadow_len == CAPACITY && $urandom_range(0, 7) == 0) growing = 1'b0;
      if (shadow_len == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      if ($urandom_range(0, 199) == 0) growing = !growing;
      pick = $urandom_range(0, 99);
      if (pick >= 98) begin
        send_request(3'($urandom_range(REQ_SEARCH + 1, REQ_LAST_CODE)),
                     pos_t'($urandom_range(0, POS_MAX)), $urandom());
      end else if (growing) begin
        if (pick < 35) begin
          send_request(REQ_INSERT, pick_position(shadow_len), random_word());
        end else if (pick < 55) begin
          pos = $urandom_range(0, 1) ? pos_t'(shadow_len) : pick_position(shadow_len);
          send_request(REQ_SET, pos, random_word());
        end else if (pick < 65) begin
          send_request(REQ_DELETE, pick_position(shadow_len - 1), random_word());
        end else if (pick < 80) begin
          send_request(REQ_GET, pick_position(shadow_len - 1), random_word());
        end else begin
          send_request(REQ_SEARCH, pos_t'($urandom_range(0, POS_MAX)), search_word());
        end
      end else begin
        if (pick < 40)
          send_request(REQ_DELETE, pick_position(shadow_len - 1), random_word());
        else if (pick < 50)
          send_request(REQ_INSERT, pick_position(shadow_len), random_word());
        else if (pick < 60)
          send_request(REQ_SET, pick_position(shadow_len), random_word());
        else if (pick < 75)
          send_request(REQ_GET, pick_position(shadow_len - 1), random_word());
        else
          send_request(REQ_SEARCH, pos_t'($urandom_range(0, POS_MAX)), search_word());
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = REQ_GET;
    position_i   = '0;
    item_value_i = '0;
    shadow_len   = 0;
    fail_count   = 0;
    burst_left   = 0;
    search_hits  = 0;
    longest_list = 0;
    replies_seen = 0;
    foreach (op_tally[k]) op_tally[k] = 0;
    foreach (status_tally[k]) status_tally[k] = 0;
    foreach (shadow_words[k]) shadow_words[k] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_edge_requests();
    test_full_list();
    test_random_traffic(1280);

    @(negedge clk_i) start <= 1'b0;
    wait (pending_replies.size() == 0);
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (pending_replies.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_replies.size()));

    $display("%0d results checked: get %0d, set %0d, insert %0d, delete %0d, search %0d, other %0d",
             replies_seen, op_tally[REQ_GET], op_tally[REQ_SET], op_tally[REQ_INSERT],
             op_tally[REQ_DELETE], op_tally[REQ_SEARCH],
             op_tally[5] + op_tally[6] + op_tally[7]);
    $display("status ok %0d, bad index %0d, full %0d, empty %0d; %0d search hits; longest %0d",
             status_tally[ST_OK], status_tally[ST_BAD_INDEX], status_tally[ST_FULL],
             status_tally[ST_EMPTY], search_hits, longest_list);
    if (fail_count == 0) begin
      $display("ordered_array_list_engine_unit regression: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("ordered_array_list_engine_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the engine");
    $display("ordered_array_list_engine_unit regression: fail");
    $finish;
  end

endmodule
